>>> rtl/kf2_pkg.sv
package kf2_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ISSUE,
        ST_OPND,
        ST_MULWB,
        ST_DIVWAIT,
        ST_DONE
    } kf2_state_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TRANS_ROW0,
        REG_TRANS_ROW1,
        REG_OBS_ROW0,
        REG_OBS_ROW1,
        REG_PNOISE_ROW0,
        REG_PNOISE_ROW1,
        REG_MNOISE_ROW0,
        REG_MNOISE_ROW1
    } kf2_reg_t;

    // Matrix-level operation kinds
    typedef enum logic [3:0] {
        MK_MV,      // c = a * v            (2 entries, 2 terms)
        MK_MM,      // c = a * b            (4 entries, 2 terms)
        MK_MMT,     // c = a * b^T          (4 entries, 2 terms)
        MK_ADD,     // c = a + b
        MK_SUB,     // c = a - b
        MK_ISUB,    // c = I - a
        MK_MOV,     // c = a
        MK_DET,     // det of 2x2 at a, branch when zero
        MK_INV,     // c = adj(a) / det
        MK_END
    } kf2_kind_t;

    localparam int MEM_DEPTH = 84;
    localparam int MEM_AW    = 7;
    localparam int PC_W      = 5;

    // Scratch memory map (one 32-bit word per entry, matrices row-major)
    localparam logic [MEM_AW-1:0] M_A    = 7'd0;
    localparam logic [MEM_AW-1:0] M_H    = 7'd4;
    localparam logic [MEM_AW-1:0] M_Q    = 7'd8;
    localparam logic [MEM_AW-1:0] M_R    = 7'd12;
    localparam logic [MEM_AW-1:0] M_X    = 7'd16;
    localparam logic [MEM_AW-1:0] M_P    = 7'd18;
    localparam logic [MEM_AW-1:0] M_Z    = 7'd22;
    localparam logic [MEM_AW-1:0] M_ONE  = 7'd24;
    localparam logic [MEM_AW-1:0] M_ZERO = 7'd25;
    localparam logic [MEM_AW-1:0] M_XP   = 7'd26;
    localparam logic [MEM_AW-1:0] M_T1   = 7'd28;
    localparam logic [MEM_AW-1:0] M_T2   = 7'd32;
    localparam logic [MEM_AW-1:0] M_PP   = 7'd36;
    localparam logic [MEM_AW-1:0] M_T3   = 7'd40;
    localparam logic [MEM_AW-1:0] M_T4   = 7'd44;
    localparam logic [MEM_AW-1:0] M_S    = 7'd48;
    localparam logic [MEM_AW-1:0] M_INV  = 7'd52;
    localparam logic [MEM_AW-1:0] M_T5   = 7'd56;
    localparam logic [MEM_AW-1:0] M_K    = 7'd60;
    localparam logic [MEM_AW-1:0] M_Y    = 7'd64;
    localparam logic [MEM_AW-1:0] M_Y2   = 7'd66;
    localparam logic [MEM_AW-1:0] M_KY   = 7'd68;
    localparam logic [MEM_AW-1:0] M_XN   = 7'd70;
    localparam logic [MEM_AW-1:0] M_T6   = 7'd72;
    localparam logic [MEM_AW-1:0] M_T7   = 7'd76;
    localparam logic [MEM_AW-1:0] M_PN   = 7'd80;

    // last word copied in before the program runs
    localparam logic [4:0] LOAD_LAST = 5'd25;

    localparam logic [PC_W-1:0] PC_SING = 5'd19;
    localparam logic [PC_W-1:0] PC_LAST = 5'd21;

    typedef struct packed {
        kf2_kind_t           kind;
        logic [MEM_AW-1:0]   dst;
        logic [MEM_AW-1:0]   a;
        logic [MEM_AW-1:0]   b;
        logic [1:0]          last;   // last entry index
    } kf2_mop_t;

    function automatic kf2_mop_t kf2_mop(input kf2_kind_t kind,
                                         input logic [MEM_AW-1:0] dst,
                                         input logic [MEM_AW-1:0] a,
                                         input logic [MEM_AW-1:0] b,
                                         input logic [1:0] last);
        kf2_mop_t m;
        m.kind = kind;
        m.dst  = dst;
        m.a    = a;
        m.b    = b;
        m.last = last;
        return m;
    endfunction

    // Filter program: predict, innovation covariance, gain, correction
    function automatic kf2_mop_t kf2_prog(input logic [PC_W-1:0] pc);
        kf2_mop_t m;
        case (pc)
            5'd0:    m = kf2_mop(MK_MV,   M_XP, M_A,  M_X,    2'd1);
            5'd1:    m = kf2_mop(MK_MM,   M_T1, M_A,  M_P,    2'd3);
            5'd2:    m = kf2_mop(MK_MMT,  M_T2, M_T1, M_A,    2'd3);
            5'd3:    m = kf2_mop(MK_ADD,  M_PP, M_T2, M_Q,    2'd3);
            5'd4:    m = kf2_mop(MK_MM,   M_T3, M_H,  M_PP,   2'd3);
            5'd5:    m = kf2_mop(MK_MMT,  M_T4, M_T3, M_H,    2'd3);
            5'd6:    m = kf2_mop(MK_ADD,  M_S,  M_T4, M_R,    2'd3);
            5'd7:    m = kf2_mop(MK_DET,  M_S,  M_S,  M_S,    2'd0);
            5'd8:    m = kf2_mop(MK_INV,  M_INV, M_S, M_ZERO, 2'd3);
            5'd9:    m = kf2_mop(MK_MMT,  M_T5, M_PP, M_H,    2'd3);
            5'd10:   m = kf2_mop(MK_MM,   M_K,  M_T5, M_INV,  2'd3);
            5'd11:   m = kf2_mop(MK_MV,   M_Y,  M_H,  M_XP,   2'd1);
            5'd12:   m = kf2_mop(MK_SUB,  M_Y2, M_Z,  M_Y,    2'd1);
            5'd13:   m = kf2_mop(MK_MV,   M_KY, M_K,  M_Y2,   2'd1);
            5'd14:   m = kf2_mop(MK_ADD,  M_XN, M_XP, M_KY,   2'd1);
            5'd15:   m = kf2_mop(MK_MM,   M_T6, M_K,  M_H,    2'd3);
            5'd16:   m = kf2_mop(MK_ISUB, M_T7, M_T6, M_ZERO, 2'd3);
            5'd17:   m = kf2_mop(MK_MM,   M_PN, M_T7, M_PP,   2'd3);
            5'd18:   m = kf2_mop(MK_END,  M_ZERO, M_ZERO, M_ZERO, 2'd0);
            // singular path: keep the prediction
            5'd19:   m = kf2_mop(MK_MOV,  M_XN, M_XP, M_ZERO, 2'd1);
            5'd20:   m = kf2_mop(MK_MOV,  M_PN, M_PP, M_ZERO, 2'd3);
            default: m = kf2_mop(MK_END,  M_ZERO, M_ZERO, M_ZERO, 2'd0);
        endcase
        return m;
    endfunction

endpackage

>>> rtl/kalman_filter_two_state_top.sv
// Two-state linear Kalman filter, signed fixed point with FRAC_BITS fraction
// bits. Each input transaction carries two measurements; each accepted item
// returns exactly one output transaction with the corrected estimate and a
// singular flag. The step is A x / A P A^T + Q prediction, S = H P' H^T + R,
// 2x2 inverse of S, gain K = P' H^T S^-1, correction and P = (I - K H) P'.
// If det(S) is zero the correction is skipped, the prediction is kept and
// singular is raised. All products run on one shared 32x32 multiplier
// under a small program sequencer, with a scratch memory holding all matrix
// words and a radix-2 divider for the four inverse entries. An item starts
// with a copy of registers, state and measurement (26 words) into the
// scratch memory, then runs product terms, adds and divides in program
// order. s_tready is high only while the sequencer is idle; the result sits
// in an output register so a new item can be taken while m_tvalid waits.
// Registers must be written only while the block is idle; the block itself
// does not enforce this.
module kalman_filter_two_state_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] meas_first, [63:32] meas_second
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] est_first, [63:32] est_second
    output logic        m_tuser,    // [0] singular
    // register write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);
    import kf2_pkg::*;

    localparam logic [31:0] ONE_W = 32'(64'd1 << FRAC_BITS);

    // configuration registers (two packed Q words per row)
    logic [63:0] cfg_reg [8];

    // filter state
    logic signed [31:0] x_reg [2];
    logic signed [31:0] p_reg [4];
    logic signed [31:0] z_reg [2];

    // sequencer
    kf2_state_t       state_reg, state_next;
    logic [PC_W-1:0]  mpc_reg, mpc_next;
    logic [1:0]       ent_reg, ent_next;
    logic             term_reg, term_next;
    logic [4:0]       load_cnt_reg, load_cnt_next;
    kf2_mop_t         mop;
    logic             adv;

    // scratch memory
    logic [31:0]        mem [MEM_DEPTH];
    logic [MEM_AW-1:0]  rd_addr_a, rd_addr_b;
    logic signed [31:0] rd_a_reg, rd_b_reg;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [31:0]        mem_wdata;
    logic [31:0]        load_word;

    // shared arithmetic
    logic signed [63:0] mul_res;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] det_reg;
    logic signed [63:0] sh;
    logic signed [63:0] mac_val;
    logic signed [63:0] det_val;
    logic signed [63:0] add_val;
    logic signed [63:0] sub_val;
    logic               prod_load, acc_load, det_load;

    // divider
    logic               div_start;
    logic               div_done;
    logic signed [32:0] div_num;
    logic signed [31:0] div_quo;
    logic [1:0]         inv_off;

    // control strobes
    logic in_take, out_load, sing_set;
    logic out_valid_reg, out_valid_next;
    logic out_sing_reg, sing_reg;
    logic [63:0] out_data_reg;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    assign mop = kf2_prog(mpc_reg);

    // ------------------------------------------------------------------
    // Operand addressing for the current entry / term
    // ------------------------------------------------------------------
    assign inv_off = (ent_reg inside {2'd0, 2'd3}) ? ~ent_reg : ent_reg;

    always_comb begin
        rd_addr_a = mop.a;
        rd_addr_b = mop.b;
        case (mop.kind)
            MK_MV: begin
                rd_addr_a = mop.a + 7'({ent_reg[0], term_reg});
                rd_addr_b = mop.b + 7'(term_reg);
            end
            MK_MM: begin
                rd_addr_a = mop.a + 7'({ent_reg[1], term_reg});
                rd_addr_b = mop.b + 7'({term_reg, ent_reg[0]});
            end
            MK_MMT: begin
                rd_addr_a = mop.a + 7'({ent_reg[1], term_reg});
                rd_addr_b = mop.b + 7'({ent_reg[0], term_reg});
            end
            MK_ADD, MK_SUB: begin
                rd_addr_a = mop.a + 7'(ent_reg);
                rd_addr_b = mop.b + 7'(ent_reg);
            end
            MK_MOV: begin
                rd_addr_a = mop.a + 7'(ent_reg);
                rd_addr_b = M_ZERO;
            end
            MK_ISUB: begin
                rd_addr_a = (ent_reg inside {2'd0, 2'd3}) ? M_ONE : M_ZERO;
                rd_addr_b = mop.a + 7'(ent_reg);
            end
            MK_DET: begin
                // s00*s11 first, then s01*s10
                rd_addr_a = term_reg ? (mop.a + 7'd1) : mop.a;
                rd_addr_b = term_reg ? (mop.a + 7'd2) : (mop.a + 7'd3);
            end
            MK_INV: begin
                rd_addr_a = mop.a + 7'(inv_off);
                rd_addr_b = M_ZERO;
            end
            default: begin
                rd_addr_a = M_ZERO;
                rd_addr_b = M_ZERO;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath values
    // ------------------------------------------------------------------
    assign mul_res = rd_a_reg * rd_b_reg;
    assign sh      = prod_reg >>> FRAC_BITS;
    assign mac_val = acc_reg + sh;
    assign det_val = acc_reg - sh;
    assign add_val = 64'(rd_a_reg) + 64'(rd_b_reg);
    assign sub_val = 64'(rd_a_reg) - 64'(rd_b_reg);

    // adjugate: diagonal entries swap, off-diagonal entries negate
    assign div_num = (ent_reg inside {2'd1, 2'd2})
                   ? (33'sd0 - 33'(rd_a_reg)) : 33'(rd_a_reg);

    always_comb begin
        load_word = 32'd0;
        if (load_cnt_reg < 5'd16) begin
            load_word = load_cnt_reg[0] ? cfg_reg[load_cnt_reg[3:1]][63:32]
                                        : cfg_reg[load_cnt_reg[3:1]][31:0];
        end else begin
            case (load_cnt_reg)
                5'(M_X):          load_word = x_reg[0];
                5'(M_X + 7'd1):   load_word = x_reg[1];
                5'(M_P):          load_word = p_reg[0];
                5'(M_P + 7'd1):   load_word = p_reg[1];
                5'(M_P + 7'd2):   load_word = p_reg[2];
                5'(M_P + 7'd3):   load_word = p_reg[3];
                5'(M_Z):          load_word = z_reg[0];
                5'(M_Z + 7'd1):   load_word = z_reg[1];
                5'(M_ONE):        load_word = ONE_W;
                default:          load_word = 32'd0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mpc_reg      <= '0;
            ent_reg      <= '0;
            term_reg     <= 1'b0;
            load_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            mpc_reg      <= mpc_next;
            ent_reg      <= ent_next;
            term_reg     <= term_next;
            load_cnt_reg <= load_cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        mpc_next      = mpc_reg;
        ent_next      = ent_reg;
        term_next     = term_reg;
        load_cnt_next = load_cnt_reg;
        mem_we        = 1'b0;
        mem_waddr     = mop.dst + 7'(ent_reg);
        mem_wdata     = 32'd0;
        prod_load     = 1'b0;
        acc_load      = 1'b0;
        det_load      = 1'b0;
        div_start     = 1'b0;
        sing_set      = 1'b0;
        in_take       = 1'b0;
        out_load      = 1'b0;
        adv           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    in_take       = 1'b1;
                    load_cnt_next = '0;
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD: begin
                mem_we    = 1'b1;
                mem_waddr = 7'(load_cnt_reg);
                mem_wdata = load_word;
                if (load_cnt_reg == LOAD_LAST) begin
                    mpc_next   = '0;
                    ent_next   = '0;
                    term_next  = 1'b0;
                    state_next = ST_ISSUE;
                end else begin
                    load_cnt_next = load_cnt_reg + 5'd1;
                end
            end
            ST_ISSUE: begin
                state_next = (mop.kind == MK_END) ? ST_DONE : ST_OPND;
            end
            ST_OPND: begin
                case (mop.kind)
                    MK_MV, MK_MM, MK_MMT, MK_DET: begin
                        prod_load  = 1'b1;
                        state_next = ST_MULWB;
                    end
                    MK_ADD, MK_MOV: begin
                        mem_we    = 1'b1;
                        mem_wdata = sat32(add_val);
                        adv       = 1'b1;
                    end
                    MK_SUB, MK_ISUB: begin
                        mem_we    = 1'b1;
                        mem_wdata = sat32(sub_val);
                        adv       = 1'b1;
                    end
                    MK_INV: begin
                        div_start  = 1'b1;
                        state_next = ST_DIVWAIT;
                    end
                    default: state_next = ST_ISSUE;
                endcase
            end
            ST_MULWB: begin
                if (!term_reg) begin
                    acc_load   = 1'b1;
                    term_next  = 1'b1;
                    state_next = ST_ISSUE;
                end else if (mop.kind == MK_DET) begin
                    det_load   = 1'b1;
                    term_next  = 1'b0;
                    ent_next   = '0;
                    state_next = ST_ISSUE;
                    if (det_val == 64'sd0) begin
                        sing_set = 1'b1;
                        mpc_next = PC_SING;
                    end else begin
                        mpc_next = mpc_reg + 5'd1;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = sat32(mac_val);
                    adv       = 1'b1;
                end
            end
            ST_DIVWAIT: begin
                if (div_done) begin
                    mem_we    = 1'b1;
                    mem_wdata = div_quo;
                    adv       = 1'b1;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // step to the next entry or the next matrix operation
        if (adv) begin
            term_next  = 1'b0;
            state_next = ST_ISSUE;
            if (ent_reg == mop.last) begin
                ent_next = '0;
                mpc_next = mpc_reg + 5'd1;
            end else begin
                ent_next = ent_reg + 2'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Scratch memory: one write port, two registered read ports
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    // ------------------------------------------------------------------
    // Arithmetic registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (prod_load) begin
            prod_reg <= mul_res;
        end
        if (acc_load) begin
            acc_reg <= sh;
        end
        if (det_load) begin
            det_reg <= det_val;
        end
    end

    kf2_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (det_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    // ------------------------------------------------------------------
    // Configuration, state and measurement registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_TRANS_ROW0]  <= 64'h0000_0001_0000_0000;
            cfg_reg[REG_TRANS_ROW1]  <= 64'h0000_0000_0001_0000;
            cfg_reg[REG_OBS_ROW0]    <= 64'h0000_0000_0001_0000;
            cfg_reg[REG_OBS_ROW1]    <= 64'h0000_0001_0000_0000;
            cfg_reg[REG_PNOISE_ROW0] <= 64'h0;
            cfg_reg[REG_PNOISE_ROW1] <= 64'h0;
            cfg_reg[REG_MNOISE_ROW0] <= 64'h0000_0000_0001_0000;
            cfg_reg[REG_MNOISE_ROW1] <= 64'h0000_0001_0000_0000;
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    // new estimate and covariance are picked off the memory write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg[0] <= '0;
            x_reg[1] <= '0;
            p_reg[0] <= '0;
            p_reg[1] <= '0;
            p_reg[2] <= '0;
            p_reg[3] <= '0;
        end else if (mem_we) begin
            case (mem_waddr)
                M_XN:          x_reg[0] <= mem_wdata;
                M_XN + 7'd1:   x_reg[1] <= mem_wdata;
                M_PN:          p_reg[0] <= mem_wdata;
                M_PN + 7'd1:   p_reg[1] <= mem_wdata;
                M_PN + 7'd2:   p_reg[2] <= mem_wdata;
                M_PN + 7'd3:   p_reg[3] <= mem_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            z_reg[0] <= s_tdata[31:0];
            z_reg[1] <= s_tdata[63:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sing_reg <= 1'b0;
        end else if (in_take) begin
            sing_reg <= 1'b0;
        end else if (sing_set) begin
            sing_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {x_reg[1], x_reg[0]};
            out_sing_reg <= sing_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sing_reg;

`ifndef NO_ASSERTIONS
    // divider completes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVWAIT))
        else $error("divider result outside divide wait");

    // entry counter never runs past the current operation
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE) |-> (ent_reg <= mop.last))
        else $error("entry index past operation size");

    // program counter stays within the program
    assert property (@(posedge aclk) disable iff (!aresetn)
        mpc_reg <= PC_LAST)
        else $error("program counter out of range");

    // a singular item never writes the inverse
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && sing_reg) |-> (mop.kind != MK_INV))
        else $error("inverse written after zero determinant");

    // a result is only loaded into a free or draining output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten");
`endif

endmodule

>>> rtl/kf2_div.sv
module kf2_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [32:0]  num,
    input  logic signed [63:0]  den,
    output logic                done,
    output logic signed [31:0]  quo
);
    // quotient of (num * 2^FRAC_BITS) / den, toward zero, saturated to 32 bits
    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] dvd_reg;
    logic [63:0]   rem_reg;
    logic [63:0]   dmag_reg;
    logic          neg_reg;

    logic [32:0]   nmag;
    logic [64:0]   trial;
    logic          fits;
    logic          ovf_pos;
    logic          ovf_neg;

    assign nmag  = num[32] ? (33'd0 - num) : num;
    assign trial = {rem_reg, dvd_reg[NW-1]};
    assign fits  = trial >= {1'b0, dmag_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= {nmag[31:0], {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            dmag_reg <= den[63] ? (64'd0 - den) : den;
            neg_reg  <= num[32] ^ den[63];
        end else if (run_reg) begin
            rem_reg <= fits ? 64'(trial - {1'b0, dmag_reg}) : trial[63:0];
            dvd_reg <= {dvd_reg[NW-2:0], fits};
        end
    end

    assign ovf_pos = |dvd_reg[NW-1:31];
    assign ovf_neg = (|dvd_reg[NW-1:32]) || (dvd_reg[31] && (|dvd_reg[30:0]));

    always_comb begin
        if (neg_reg) begin
            quo = ovf_neg ? 32'sh8000_0000 : (32'sd0 - signed'(dvd_reg[31:0]));
        end else begin
            quo = ovf_pos ? 32'sh7fff_ffff : signed'(dvd_reg[31:0]);
        end
    end

    assign done = done_reg;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import kf2_pkg::*;

    localparam int FRAC = 16;
    localparam longint ONE_Q = 64'sd1 << FRAC;
    // idle cycles tolerated with no transaction on either side
    localparam int WATCHDOG_LIMIT = 20000;
    // tail wait after the last result
    localparam int TAIL_CYCLES = 600;

    typedef longint mat_t [4];
    typedef longint vec_t [2];

    typedef struct {
        logic [31:0] est_first;
        logic [31:0] est_second;
        logic        singular;
    } est_item_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;     // [31:0] meas_first, [63:32] meas_second
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;     // [31:0] est_first, [63:32] est_second
    logic        m_tuser;     // [0] singular
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;

    // filter model: shadow registers plus its own estimate and covariance
    logic [63:0] kf_reg [8];
    longint      kf_est [2];
    longint      kf_cov [4];

    est_item_t est_queue [$];
    int        n_errors = 0;
    int        burst_left;
    int        idle_cycles = 0;
    int        stall_cnt = 0;
    int        stall_mode = 0;

    kalman_filter_two_state_top #(.FRAC_BITS(FRAC)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // fixed-point helpers
    // ---------------------------------------------------------------
    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // exact product, then floor shift
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> FRAC;
    endfunction

    function automatic longint sext32(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic mat_t row_pair(input logic [63:0] r0, input logic [63:0] r1);
        mat_t m;
        m[0] = sext32(r0[31:0]);
        m[1] = sext32(r0[63:32]);
        m[2] = sext32(r1[31:0]);
        m[3] = sext32(r1[63:32]);
        return m;
    endfunction

    function automatic mat_t transp(input mat_t a);
        mat_t t;
        t[0] = a[0]; t[1] = a[2]; t[2] = a[1]; t[3] = a[3];
        return t;
    endfunction

    function automatic mat_t mat_mul(input mat_t a, input mat_t b);
        mat_t c;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                c[i*2+j] = sat32(qmul(a[i*2], b[j]) + qmul(a[i*2+1], b[2+j]));
        return c;
    endfunction

    function automatic vec_t mat_vec(input mat_t m, input vec_t v);
        vec_t o;
        o[0] = sat32(qmul(m[0], v[0]) + qmul(m[1], v[1]));
        o[1] = sat32(qmul(m[2], v[0]) + qmul(m[3], v[1]));
        return o;
    endfunction

    function automatic mat_t mat_add(input mat_t a, input mat_t b);
        mat_t c;
        for (int i = 0; i < 4; i++) c[i] = sat32(a[i] + b[i]);
        return c;
    endfunction

    // one filter step on the model state; returns the expected output
    function automatic est_item_t kf_update(input logic [31:0] z0, input logic [31:0] z1);
        mat_t a, h, q, r, pp, t, s, inv, k;
        vec_t xp, y, ky, x;
        longint det;
        est_item_t e;
        a = row_pair(kf_reg[REG_TRANS_ROW0], kf_reg[REG_TRANS_ROW1]);
        h = row_pair(kf_reg[REG_OBS_ROW0], kf_reg[REG_OBS_ROW1]);
        q = row_pair(kf_reg[REG_PNOISE_ROW0], kf_reg[REG_PNOISE_ROW1]);
        r = row_pair(kf_reg[REG_MNOISE_ROW0], kf_reg[REG_MNOISE_ROW1]);
        x = kf_est;
        xp = mat_vec(a, x);
        t = mat_mul(a, kf_cov);
        t = mat_mul(t, transp(a));
        pp = mat_add(t, q);
        t = mat_mul(h, pp);
        t = mat_mul(t, transp(h));
        s = mat_add(t, r);
        det = qmul(s[0], s[3]) - qmul(s[1], s[2]);
        if (det == 0) begin
            e.singular = 1'b1;
            kf_est = xp;
            kf_cov = pp;
        end else begin
            e.singular = 1'b0;
            inv[0] = sat32((s[3] * ONE_Q) / det);
            inv[1] = sat32((-s[1] * ONE_Q) / det);
            inv[2] = sat32((-s[2] * ONE_Q) / det);
            inv[3] = sat32((s[0] * ONE_Q) / det);
            k = mat_mul(mat_mul(pp, transp(h)), inv);
            y = mat_vec(h, xp);
            y[0] = sat32(sext32(z0) - y[0]);
            y[1] = sat32(sext32(z1) - y[1]);
            ky = mat_vec(k, y);
            kf_est[0] = sat32(xp[0] + ky[0]);
            kf_est[1] = sat32(xp[1] + ky[1]);
            t = mat_mul(k, h);
            for (int i = 0; i < 4; i++)
                t[i] = sat32(((i inside {0, 3}) ? ONE_Q : 64'sd0) - t[i]);
            kf_cov = mat_mul(t, pp);
        end
        e.est_first = kf_est[0][31:0];
        e.est_second = kf_est[1][31:0];
        return e;
    endfunction

    // ---------------------------------------------------------------
    // reporting, driving
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // one register write per call; caller must be on a rising edge
    task automatic cfg_write(input kf2_reg_t idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        kf_reg[idx] = val;
        @(posedge aclk);
    endtask

    task automatic cfg_done();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // sender in bursts: gap before a new burst, valid held through one
    task automatic send_meas(input logic [31:0] z0, input logic [31:0] z1);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z1, z0};
        do @(posedge aclk); while (!s_tready);
        est_queue.push_back(kf_update(z0, z1));
        burst_left--;
    endtask

    // stop sending and wait until every result is back; block is idle then
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (est_queue.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_q(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [31:0] rand_meas();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return {$urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000};
            default: return rand_q(100 << FRAC);
        endcase
    endfunction

    task automatic write_all(input logic [63:0] v [8]);
        for (int i = 0; i < 8; i++) cfg_write(kf2_reg_t'(i), v[i]);
        cfg_done();
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_reset_defaults();
        send_meas(32'h0000_0000, 32'h0000_0000);
        send_meas(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_meas(32'h8000_0000, 32'h8000_0000);
        send_meas(32'h7FFF_FFFF, 32'h8000_0000);
        send_meas(32'h0001_0000, 32'hFFFF_0000);
        drain();
    endtask

    // zero H and zero R give S = 0, so det is zero and correction is skipped
    task automatic test_singular();
        logic [63:0] v [8];
        v = '{64'h0000_0000_0001_0000, 64'h0001_0000_0000_0000, 64'd0, 64'd0,
              64'h0000_0000_0000_4000, 64'h0000_4000_0000_0000, 64'd0, 64'd0};
        write_all(v);
        send_meas(32'h0003_0000, 32'hFFFD_0000);
        send_meas(32'h7FFF_FFFF, 32'h8000_0000);
        send_meas($urandom(), $urandom());
        drain();
    endtask

    task automatic test_config_extremes();
        logic [63:0] v [8];
        for (int i = 0; i < 8; i++) v[i] = 64'hFFFF_FFFF_FFFF_FFFF;
        write_all(v);
        send_meas(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_meas(32'h8000_0000, 32'h0000_0000);
        drain();
        for (int i = 0; i < 8; i++) v[i] = 64'h7FFF_FFFF_8000_0000;
        write_all(v);
        send_meas(32'h7FFF_FFFF, 32'h8000_0000);
        send_meas(32'h0000_0000, 32'h7FFF_FFFF);
        drain();
        for (int i = 0; i < 8; i++) v[i] = 64'h8000_0000_7FFF_FFFF;
        write_all(v);
        send_meas(32'h8000_0000, 32'h8000_0000);
        send_meas(32'h1234_5678, 32'h8765_4321);
        drain();
        for (int i = 0; i < 8; i++) v[i] = 64'd0;
        write_all(v);
        send_meas(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();
    endtask

    // phases of random configuration, mostly well-conditioned filters
    task automatic test_random(input int n_items);
        logic [63:0] v [8];
        int sent, len, mode;
        sent = 0;
        while (sent < n_items) begin
            mode = $urandom_range(0, 9);
            for (int i = 0; i < 8; i++) begin
                if (mode == 0) v[i] = {$urandom(), $urandom()};
                else if (mode == 1 && i >= 2 && i != 4 && i != 5) v[i] = 64'd0;
                else if (i < 4) v[i] = {rand_q(80000), rand_q(80000)};
                else v[i] = {rand_q(20000), rand_q(20000)};
            end
            write_all(v);
            len = $urandom_range(20, 60);
            for (int j = 0; j < len; j++) send_meas(rand_meas(), rand_meas());
            sent += len;
            drain();
        end
    endtask

    // ---------------------------------------------------------------
    // receiver stall pattern, result checker, watchdog
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        est_item_t e;
        logic      acc;
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_cnt = $urandom_range(50, 400);
        end else begin
            stall_cnt--;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase

        if (aresetn && m_tvalid && m_tready) begin
            if (est_queue.size() == 0) begin
                report_mismatch("unexpected result transaction", m_tdata[31:0], 0);
            end else begin
                e = est_queue.pop_front();
                if (m_tdata[31:0] !== e.est_first)
                    report_mismatch("est_first", sext32(m_tdata[31:0]), sext32(e.est_first));
                if (m_tdata[63:32] !== e.est_second)
                    report_mismatch("est_second", sext32(m_tdata[63:32]),
                                    sext32(e.est_second));
                if (m_tuser !== e.singular)
                    report_mismatch("singular", m_tuser, e.singular);
            end
        end

        acc = (s_tvalid && s_tready) || (m_tvalid && m_tready);
        if (acc || !aresetn) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        burst_left = 0;
        // reset values of the register file
        kf_reg[REG_TRANS_ROW0] = 64'h0000_0001_0000_0000;
        kf_reg[REG_TRANS_ROW1] = 64'h0000_0000_0001_0000;
        kf_reg[REG_OBS_ROW0] = 64'h0000_0000_0001_0000;
        kf_reg[REG_OBS_ROW1] = 64'h0000_0001_0000_0000;
        kf_reg[REG_PNOISE_ROW0] = 64'd0;
        kf_reg[REG_PNOISE_ROW1] = 64'd0;
        kf_reg[REG_MNOISE_ROW0] = 64'h0000_0000_0001_0000;
        kf_reg[REG_MNOISE_ROW1] = 64'h0000_0001_0000_0000;
        kf_est = '{0, 0};
        kf_cov = '{0, 0, 0, 0};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_singular();
        test_config_extremes();
        test_random(1730);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/kf2_pkg.sv
rtl/kf2_div.sv
rtl/kalman_filter_two_state_top.sv
tb/tb_top.sv
